// ===== src/mtss_pkg.sv =====
// ----------------------------------------------------------------------------
// Mip texture store package
// Shared payload types and command codes of the texture store and sampler.
// ----------------------------------------------------------------------------
package mtss_pkg;

	typedef enum logic [2:0] {
		CMD_BEGIN  = 3'd0,
		CMD_TEXEL  = 3'd1,
		CMD_CLEAR  = 3'd2,
		CMD_QUERY  = 3'd3,
		CMD_SAMPLE = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [2:0]  face;
		logic [31:0] texel;
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] stride;
		logic [15:0] u_coord;
		logic [15:0] v_coord;
		logic [3:0]  mip_level;
	} req_t;

	typedef struct packed {
		logic        status;
		logic        present;
		logic        upload_done;
		logic [31:0] color;
	} rsp_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_WRITE,
		OP_BUILD_RD,
		OP_BUILD_WR,
		OP_SMP_SETUP,
		OP_SMP_RD,
		OP_SMP_MIX
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] tap;
	} dp_cmd_t;

endpackage

// ===== src/mipmap_texture_store_sampler.sv =====
// ----------------------------------------------------------------------------
// Mipmapped texture store and bilinear sampler
// Stores one square RGBA texture per face with its mip pyramid and samples it.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; exactly one
// result beat follows, shown for one cycle with done high, and the receiver
// cannot stall it. Begin, clear, query, rejected commands, samples of a bad or
// absent face and texels that are not the last are answered from idle with a
// registered result in the cycle after they are taken. The last texel of an
// upload starts the pyramid build, which runs through the single memory port;
// each built texel takes four reads, each followed by a wait state for the
// registered read data, and one write. A sample of a present face runs
// through setup, four reads through the memory port, each with a wait for
// its registered read data, the blend and the result.
module mipmap_texture_store_sampler #(
	parameter int TEXTURE_SIZE = 64,
	parameter int FACE_COUNT   = 6,
	parameter int MIP_LEVELS   = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mtss_pkg::req_t  req,
	output logic            busy,
	output logic            done,
	output mtss_pkg::rsp_t  rsp
);
	import mtss_pkg::*;

	// Address covers every face and its pyramid.
	localparam int DEPTH = FACE_COUNT * ((4 * TEXTURE_SIZE * TEXTURE_SIZE - 1) / 3 + MIP_LEVELS);
	localparam int AW = $clog2(DEPTH);
	localparam int DW = $clog2(TEXTURE_SIZE) + 1;

	dp_cmd_t       cmd;
	logic [AW-1:0] addr;
	logic [31:0]   wdata, color;
	logic [DW-1:0] dim_m1, x0, y0;
	logic [15:0]   u_coord, v_coord;

	mtss_ctrl #(.TEXTURE_SIZE(TEXTURE_SIZE), .FACE_COUNT(FACE_COUNT),
		.MIP_LEVELS(MIP_LEVELS), .AW(AW), .DW(DW)) u_ctrl (
		.clk, .arst_n, .start, .req, .busy, .done, .rsp, .cmd, .addr, .wdata,
		.dim_m1, .u_coord, .v_coord, .x0, .y0, .color
	);

	mtss_datapath #(.TEXTURE_SIZE(TEXTURE_SIZE), .FACE_COUNT(FACE_COUNT),
		.MIP_LEVELS(MIP_LEVELS), .AW(AW), .DW(DW)) u_dp (
		.clk, .cmd, .addr, .wdata, .dim_m1, .u_coord, .v_coord, .x0, .y0, .color
	);
endmodule

// ===== src/mtss_datapath.sv =====
// ----------------------------------------------------------------------------
// Mip texture store datapath
// Texel memory, box-filter accumulator and bilinear filter arithmetic.
// ----------------------------------------------------------------------------
module mtss_datapath #(
	parameter int TEXTURE_SIZE = 64,
	parameter int FACE_COUNT   = 6,
	parameter int MIP_LEVELS   = 7,
	parameter int AW           = 16,
	parameter int DW           = 9
) (
	input  logic                clk,
	input  mtss_pkg::dp_cmd_t   cmd,
	input  logic [AW-1:0]       addr,
	input  logic [31:0]         wdata,
	input  logic [DW-1:0]       dim_m1,
	input  logic [15:0]         u_coord,
	input  logic [15:0]         v_coord,
	output logic [DW-1:0]       x0,
	output logic [DW-1:0]       y0,
	output logic [31:0]         color
);
	import mtss_pkg::*;

	localparam int LVL0 = TEXTURE_SIZE * TEXTURE_SIZE;
	localparam int FACE_TEXELS = (4 * LVL0 - 1) / 3 + MIP_LEVELS;
	localparam int DEPTH = FACE_COUNT * FACE_TEXELS;

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rd_q;
	logic [31:0] tap_q [4];
	logic [15:0] fx_q, fy_q;
	logic [31:0] ux, vy;
	logic [31:0] mix;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE || cmd.op == OP_BUILD_WR) begin
			mem_q[addr] <= (cmd.op == OP_WRITE) ? wdata : mix;
		end
		rd_q <= mem_q[addr];
	end

	assign ux = {16'd0, u_coord} * {{(32-DW){1'b0}}, dim_m1} ;
	assign vy = {16'd0, v_coord} * {{(32-DW){1'b0}}, dim_m1};
	assign x0 = ux[16 +: DW];
	assign y0 = vy[16 +: DW];

	// One channel a lane; the box filter and the bilinear blend share the taps.
	always_comb begin
		mix = '0;
		for (int c = 0; c < 4; c++) begin
			logic [9:0]  s;
			logic [40:0] t, b, o;
			s = {2'd0, tap_q[0][8*c +: 8]} + {2'd0, tap_q[1][8*c +: 8]}
			  + {2'd0, tap_q[2][8*c +: 8]} + {2'd0, tap_q[3][8*c +: 8]} + 10'd2;
			t = ({33'd0, tap_q[0][8*c +: 8]} * (41'd65536 - {25'd0, fx_q})
			  +  {33'd0, tap_q[1][8*c +: 8]} * {25'd0, fx_q}) >> 16;
			b = ({33'd0, tap_q[2][8*c +: 8]} * (41'd65536 - {25'd0, fx_q})
			  +  {33'd0, tap_q[3][8*c +: 8]} * {25'd0, fx_q}) >> 16;
			o = (t * (41'd65536 - {25'd0, fy_q}) + b * {25'd0, fy_q}) >> 16;
			if (cmd.op == OP_BUILD_WR) mix[8*c +: 8] = s[9:2];
			else mix[8*c +: 8] = o[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_SMP_SETUP) begin
			fx_q <= ux[15:0];
			fy_q <= vy[15:0];
		end
		if (cmd.op == OP_BUILD_RD || cmd.op == OP_SMP_RD) tap_q[cmd.tap] <= rd_q;
		if (cmd.op == OP_SMP_MIX) color <= mix;
	end
endmodule

// ===== src/mtss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mip texture store controller
// Command decode, upload bookkeeping, pyramid build and sample sequencing.
// ----------------------------------------------------------------------------
module mtss_ctrl #(
	parameter int TEXTURE_SIZE = 64,
	parameter int FACE_COUNT   = 6,
	parameter int MIP_LEVELS   = 7,
	parameter int AW           = 16,
	parameter int DW           = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mtss_pkg::req_t      req,
	output logic                busy,
	output logic                done,
	output mtss_pkg::rsp_t      rsp,
	output mtss_pkg::dp_cmd_t   cmd,
	output logic [AW-1:0]       addr,
	output logic [31:0]         wdata,
	output logic [DW-1:0]       dim_m1,
	output logic [15:0]         u_coord,
	output logic [15:0]         v_coord,
	input  logic [DW-1:0]       x0,
	input  logic [DW-1:0]       y0,
	input  logic [31:0]         color
);
	import mtss_pkg::*;

	localparam int LVL0 = TEXTURE_SIZE * TEXTURE_SIZE;
	localparam int FACE_TEXELS = (4 * LVL0 - 1) / 3 + MIP_LEVELS;
	localparam int LW = $clog2(MIP_LEVELS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_BUILD_RD, ST_BUILD_WAIT, ST_BUILD_WR,
		ST_SMP_SETUP, ST_SMP_RD, ST_SMP_WAIT, ST_SMP_MIX, ST_SMP_OUT
	} state_t;

	function automatic logic [DW-1:0] ldim(input logic [LW-1:0] l);
		int d;
		d = TEXTURE_SIZE >> l;
		return (d == 0) ? DW'(1) : DW'(d);
	endfunction

	function automatic logic [AW-1:0] lbase(input logic [LW-1:0] l);
		int o;
		o = 0;
		for (int i = 0; i < MIP_LEVELS; i++)
			if (i < int'(l)) o += int'(ldim(LW'(i))) * int'(ldim(LW'(i)));
		return AW'(o);
	endfunction

	state_t          state_q;
	logic [FACE_COUNT-1:0] pres_q;
	logic            open_q;
	logic [2:0]      uface_q, face_q;
	logic [AW-1:0]   cnt_q, fbase_q;
	logic [LW-1:0]   lvl_q;
	logic [DW-1:0]   bx_q, by_q, sx1_q, sy1_q;
	logic [1:0]      tap_q;
	logic [15:0]     u_q, v_q;
	logic [AW-1:0]   face_base;
	logic [DW-1:0]   sd, dd, sx, sy, sxa, sya, x1, y1;
	logic            face_ok;

	assign face_ok   = {1'b0, req.face} < 4'(FACE_COUNT);
	assign face_base = AW'(int'(face_q) * FACE_TEXELS);
	assign busy      = state_q != ST_IDLE;
	assign wdata     = req.texel;
	assign u_coord   = u_q;
	assign v_coord   = v_q;
	assign dd        = ldim(lvl_q);
	assign sd        = ldim(lvl_q - LW'(1));
	assign dim_m1    = dd - DW'(1);
	assign sx        = DW'({bx_q, 1'b0});
	assign sy        = DW'({by_q, 1'b0});
	assign sxa       = (sx + DW'(1) < sd) ? sx + DW'(1) : sx;
	assign sya       = (sy + DW'(1) < sd) ? sy + DW'(1) : sy;
	assign x1        = (x0 + DW'(1) < dd) ? x0 + DW'(1) : x0;
	assign y1        = (y0 + DW'(1) < dd) ? y0 + DW'(1) : y0;

	always_comb begin
		cmd  = '{op: OP_NONE, tap: tap_q};
		addr = '0;
		unique case (state_q)
			ST_IDLE: begin
				addr = AW'(int'(uface_q) * FACE_TEXELS) + cnt_q;
				if (start && req.command == CMD_TEXEL && open_q) cmd.op = OP_WRITE;
			end
			ST_BUILD_RD, ST_BUILD_WAIT: begin
				addr = face_base + lbase(lvl_q - LW'(1))
				     + AW'(tap_q[1] ? sya : sy) * AW'(sd) + AW'(tap_q[0] ? sxa : sx);
				if (state_q == ST_BUILD_WAIT) begin
					cmd.op = OP_BUILD_RD;
					cmd.tap = tap_q - 2'd1;
				end
			end
			ST_BUILD_WR: begin
				cmd.op = OP_BUILD_WR;
				addr = face_base + lbase(lvl_q) + AW'(by_q) * AW'(dd) + AW'(bx_q);
			end
			ST_SMP_SETUP: cmd.op = OP_SMP_SETUP;
			ST_SMP_RD, ST_SMP_WAIT: begin
				addr = face_base + lbase(lvl_q)
				     + AW'(tap_q[1] ? sy1_q : by_q) * AW'(dd)
				     + AW'(tap_q[0] ? sx1_q : bx_q);
				if (state_q == ST_SMP_WAIT) begin
					cmd.op = OP_SMP_RD;
					cmd.tap = tap_q - 2'd1;
				end
			end
			ST_SMP_MIX: cmd.op = OP_SMP_MIX;
			ST_SMP_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pres_q  <= '0;
			open_q  <= 1'b0;
			uface_q <= '0;
			cnt_q   <= '0;
			done    <= 1'b0;
			rsp     <= '0;
			lvl_q   <= '0;
			tap_q   <= '0;
			face_q  <= '0;
			bx_q <= '0; by_q <= '0; sx1_q <= '0; sy1_q <= '0;
			u_q <= '0; v_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) begin
					rsp <= '0;
					done <= 1'b1;
					face_q <= req.face;
					unique case (req.command)
						CMD_BEGIN: begin
							if (!face_ok || req.width != 16'(TEXTURE_SIZE)
							    || req.height != 16'(TEXTURE_SIZE)
							    || req.stride < 16'(4 * TEXTURE_SIZE)) rsp.status <= 1'b1;
							else begin
								open_q <= 1'b1;
								uface_q <= req.face;
								cnt_q <= '0;
								pres_q[req.face] <= 1'b0;
							end
						end
						CMD_TEXEL: begin
							if (!open_q) rsp.status <= 1'b1;
							else if (cnt_q == AW'(LVL0 - 1)) begin
								cnt_q <= '0;
								open_q <= 1'b0;
								face_q <= uface_q;
								lvl_q <= LW'(1);
								bx_q <= '0; by_q <= '0; tap_q <= '0;
								done <= 1'b0;
								state_q <= ST_BUILD_RD;
							end else cnt_q <= cnt_q + AW'(1);
						end
						CMD_CLEAR: if (!face_ok) rsp.status <= 1'b1;
						           else pres_q[req.face] <= 1'b0;
						CMD_QUERY: rsp.present <= face_ok && pres_q[req.face];
						CMD_SAMPLE: begin
							if (!face_ok) begin
								rsp.status <= 1'b1;
								rsp.color <= '1;
							end else if (pres_q[req.face]) begin
								done <= 1'b0;
								lvl_q <= (req.mip_level >= 4'(MIP_LEVELS))
								       ? LW'(MIP_LEVELS - 1) : LW'(req.mip_level);
								u_q <= req.u_coord;
								v_q <= req.v_coord;
								tap_q <= '0;
								state_q <= ST_SMP_SETUP;
							end
						end
						default: rsp.status <= 1'b1;
					endcase
				end
				ST_BUILD_RD: begin
					tap_q <= tap_q + 2'd1;
					state_q <= ST_BUILD_WAIT;
				end
				ST_BUILD_WAIT: state_q <= (tap_q == 2'd0) ? ST_BUILD_WR : ST_BUILD_RD;
				ST_BUILD_WR: begin
					state_q <= ST_BUILD_RD;
					if (bx_q != dd - DW'(1)) bx_q <= bx_q + DW'(1);
					else begin
						bx_q <= '0;
						if (by_q != dd - DW'(1)) by_q <= by_q + DW'(1);
						else begin
							by_q <= '0;
							if (lvl_q == LW'(MIP_LEVELS - 1)) begin
								pres_q[face_q] <= 1'b1;
								rsp <= '{status: 1'b0, present: 1'b0, upload_done: 1'b1,
								         color: '0};
								done <= 1'b1;
								state_q <= ST_IDLE;
							end else lvl_q <= lvl_q + LW'(1);
						end
					end
				end
				ST_SMP_SETUP: begin
					bx_q <= x0; by_q <= y0; sx1_q <= x1; sy1_q <= y1;
					state_q <= ST_SMP_RD;
				end
				ST_SMP_RD: begin
					tap_q <= tap_q + 2'd1;
					state_q <= ST_SMP_WAIT;
				end
				ST_SMP_WAIT: state_q <= (tap_q == 2'd0) ? ST_SMP_MIX : ST_SMP_RD;
				ST_SMP_MIX: state_q <= ST_SMP_OUT;
				ST_SMP_OUT: begin
					rsp.color <= color;
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
